// ===== src/bfr_pkg.sv =====
// Shared types and constants for the brightness fade ramp.
// Used by bfr_divider, bfr_planner and brightness_fade_ramp_core.
package bfr_pkg;

  localparam int LEVEL_W    = 10;
  localparam int BRIGHT_W   = 8;
  localparam int STEP_W     = 14;
  localparam int DELAY_W    = 16;
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int DVD_W      = 17;  // 10*(d-1) + T - 1 stays below 2^17
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  localparam int IN_FULL     = 255;
  localparam int OUT_FULL    = 1023;
  localparam int MIN_STEP_MS = 10;
  localparam int BRIGHT_THIRD = IN_FULL / 3;

  localparam logic [TIME_W-1:0]  TRANS_RESET = TIME_W'(1000);
  localparam logic [DELAY_W-1:0] MAXD_RESET  = DELAY_W'(100);

  // request opcodes
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 1'b1;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DELAY_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
    logic [DELAY_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] span;       // distance minus one, at least one
    logic [TIME_W-1:0]  trans_time; // nonzero
    logic [DELAY_W-1:0] max_delay;
  } plan_req_t;

  typedef struct packed {
    logic               done;
    logic [STEP_W-1:0]  step_size;
    logic [DELAY_W-1:0] step_delay;
  } plan_rsp_t;

endpackage

// ===== src/bfr_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bfr_pkg for widths and the request/response structs.
module bfr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  bfr_pkg::div_req_t req,
  output bfr_pkg::div_rsp_t rsp
);
  import bfr_pkg::*;

  logic [DVD_W-1:0]     dvd_r;   // dividend shifts out, quotient shifts in
  logic [DELAY_W-1:0]   rem_r;
  logic [DELAY_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DELAY_W:0] trial;
  logic [DELAY_W:0] diff;
  logic             fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DELAY_W-1:0] : trial[DELAY_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== src/bfr_planner.sv =====
// Fade planner: step size and step delay from distance and transition time.
// Depends on bfr_pkg; runs two divides in turn on one bfr_divider.
module bfr_planner (
  input  logic               clk,
  input  logic               rst_n,
  input  bfr_pkg::plan_req_t req,
  output bfr_pkg::plan_rsp_t rsp
);
  import bfr_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_DIV1,
    P_WAIT1,
    P_DIV2,
    P_WAIT2
  } plan_state_t;

  plan_state_t        state_r;
  logic [LEVEL_W-1:0] span_r;
  logic [TIME_W-1:0]  time_r;
  logic [DELAY_W-1:0] maxd_r;
  logic [DVD_W-1:0]   num_r;
  logic [DVD_W-1:0]   prod_r;
  logic [STEP_W-1:0]  step_r;
  div_req_t           div_req_r;
  plan_rsp_t          rsp_r;
  div_rsp_t           div_rsp;

  logic [DVD_W-1:0] num_in;

  // ceil(10*span / T) as floor((10*span + T - 1) / T)
  assign num_in = DVD_W'({req.span, 3'b000}) + DVD_W'({req.span, 1'b0})
                + DVD_W'(req.trans_time) - DVD_W'(1);

  bfr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= P_IDLE;
      div_req_r.start <= 1'b0;
      rsp_r.done      <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      rsp_r.done      <= 1'b0;
      unique case (state_r)
        P_IDLE: begin
          if (req.start) begin
            span_r  <= req.span;
            time_r  <= req.trans_time;
            maxd_r  <= req.max_delay;
            num_r   <= num_in;
            state_r <= P_DIV1;
          end
        end
        P_DIV1: begin
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= num_r;
          div_req_r.divisor  <= time_r;
          state_r            <= P_WAIT1;
        end
        P_WAIT1: begin
          if (div_rsp.done) begin
            step_r  <= div_rsp.quotient[STEP_W-1:0];
            // step * T falls out as dividend minus remainder
            prod_r  <= num_r - DVD_W'(div_rsp.remainder);
            state_r <= P_DIV2;
          end
        end
        P_DIV2: begin
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= prod_r;
          div_req_r.divisor  <= DELAY_W'(span_r);
          state_r            <= P_WAIT2;
        end
        P_WAIT2: begin
          if (div_rsp.done) begin
            rsp_r.done      <= 1'b1;
            rsp_r.step_size <= step_r;
            if (div_rsp.quotient > DVD_W'(maxd_r)) begin
              rsp_r.step_delay <= maxd_r;
            end else begin
              rsp_r.step_delay <= div_rsp.quotient[DELAY_W-1:0];
            end
            state_r <= P_IDLE;
          end
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== src/brightness_fade_ramp_core.sv =====
// Fade engine for one 10-bit linear light level. A tick request, and a set request
// whose distance to the new target is zero or one, is answered at the edge that
// accepts it, so its result is offered from the next cycle and the next request
// can be taken then. A longer fade is planned by two 17-step restoring divides on
// one bit-serial divider; the result of such a set request is registered once both
// divides are through, and no further request is taken before then. One request is
// in work at a time; the next is taken as soon as the result register is free or
// being emptied. Config writes are always ready.
// Depends on bfr_pkg, bfr_planner and bfr_divider.
module brightness_fade_ramp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic                            in_turn_on,
  input  logic [bfr_pkg::BRIGHT_W-1:0]    in_bright_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bfr_pkg::LEVEL_W-1:0]     out_level,
  output logic                            out_fading,
  output logic                            out_stepped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfr_pkg::DELAY_W-1:0]     cfg_data
);
  import bfr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_PLAN
  } core_state_t;

  core_state_t        state_r;
  logic [TIME_W-1:0]  trans_time_r;
  logic [DELAY_W-1:0] max_delay_r;
  logic [LEVEL_W-1:0] cur_level_r;
  logic [LEVEL_W-1:0] target_level_r;
  logic               is_fading_r;
  logic [STEP_W-1:0]  step_size_r;
  logic [DELAY_W-1:0] step_delay_r;
  logic [DELAY_W-1:0] wait_left_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_fading_r;
  logic               out_stepped_r;

  logic               in_acc;
  logic [1:0]         bright_frac;
  logic [LEVEL_W-1:0] target_new;
  logic [LEVEL_W-1:0] lvl_gap;
  plan_req_t          plan_req;
  plan_rsp_t          plan_rsp;

  logic [DELAY_W-1:0] wait_dec;
  logic [STEP_W:0]    up_sum;
  logic [LEVEL_W-1:0] down_gap;
  logic [LEVEL_W-1:0] tick_level;
  logic               tick_fading;
  logic               tick_stepped;
  logic [DELAY_W-1:0] tick_wait;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_time_r <= TRANS_RESET;
      max_delay_r  <= MAXD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRANSITION: trans_time_r <= cfg_data;
        CFG_MAX_DELAY:  max_delay_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // bri*1023/255 = 4*bri + floor(bri/85)
  always_comb begin
    if (in_bright_in >= BRIGHT_W'(3 * BRIGHT_THIRD)) begin
      bright_frac = 2'd3;
    end else if (in_bright_in >= BRIGHT_W'(2 * BRIGHT_THIRD)) begin
      bright_frac = 2'd2;
    end else if (in_bright_in >= BRIGHT_W'(BRIGHT_THIRD)) begin
      bright_frac = 2'd1;
    end else begin
      bright_frac = 2'd0;
    end
  end

  assign target_new = in_turn_on ? ({in_bright_in, 2'b00} + LEVEL_W'(bright_frac))
                                 : '0;
  assign lvl_gap = (target_new > cur_level_r) ? (target_new - cur_level_r)
                                              : (cur_level_r - target_new);

  assign plan_req.start      = in_acc && (in_func == FUNC_SET) && (lvl_gap > LEVEL_W'(1));
  assign plan_req.span       = lvl_gap - LEVEL_W'(1);
  assign plan_req.trans_time = (trans_time_r == '0) ? TIME_W'(1) : trans_time_r;
  assign plan_req.max_delay  = max_delay_r;

  bfr_planner u_planner (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (plan_req),
    .rsp   (plan_rsp)
  );

  // tick: count down, then move one step toward the target
  assign wait_dec = (wait_left_r != '0) ? (wait_left_r - DELAY_W'(1)) : '0;
  assign up_sum   = (STEP_W + 1)'(cur_level_r) + (STEP_W + 1)'(step_size_r);
  assign down_gap = cur_level_r - target_level_r;

  always_comb begin
    tick_level   = cur_level_r;
    tick_fading  = is_fading_r;
    tick_stepped = 1'b0;
    tick_wait    = wait_left_r;
    if (is_fading_r) begin
      if (wait_dec != '0) begin
        tick_wait = wait_dec;
      end else begin
        if (cur_level_r < target_level_r) begin
          tick_level = (up_sum > (STEP_W + 1)'(target_level_r)) ? target_level_r
                                                                : up_sum[LEVEL_W-1:0];
        end else if (cur_level_r > target_level_r) begin
          tick_level = (STEP_W'(down_gap) < step_size_r) ? target_level_r
                       : (cur_level_r - step_size_r[LEVEL_W-1:0]);
        end
        tick_fading  = (tick_level != target_level_r);
        tick_stepped = 1'b1;
        tick_wait    = step_delay_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cur_level_r    <= '0;
      target_level_r <= '0;
      is_fading_r    <= 1'b0;
      step_size_r    <= '0;
      step_delay_r   <= '0;
      wait_left_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_func == FUNC_SET) begin
              target_level_r <= target_new;
              if (lvl_gap == '0) begin
                is_fading_r   <= 1'b0;
                out_valid_r   <= 1'b1;
                out_level_r   <= cur_level_r;
                out_fading_r  <= 1'b0;
                out_stepped_r <= 1'b0;
              end else if (lvl_gap == LEVEL_W'(1)) begin
                step_size_r   <= STEP_W'(1);
                step_delay_r  <= '0;
                wait_left_r   <= '0;
                is_fading_r   <= 1'b1;
                out_valid_r   <= 1'b1;
                out_level_r   <= cur_level_r;
                out_fading_r  <= 1'b1;
                out_stepped_r <= 1'b0;
              end else begin
                state_r <= S_PLAN;
              end
            end else begin
              cur_level_r   <= tick_level;
              is_fading_r   <= tick_fading;
              wait_left_r   <= tick_wait;
              out_valid_r   <= 1'b1;
              out_level_r   <= tick_level;
              out_fading_r  <= tick_fading;
              out_stepped_r <= tick_stepped;
            end
          end
        end
        S_PLAN: begin
          if (plan_rsp.done) begin
            step_size_r   <= plan_rsp.step_size;
            step_delay_r  <= plan_rsp.step_delay;
            wait_left_r   <= '0;
            is_fading_r   <= 1'b1;
            out_valid_r   <= 1'b1;
            out_level_r   <= cur_level_r;
            out_fading_r  <= 1'b1;
            out_stepped_r <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_fading  = out_fading_r;
  assign out_stepped = out_stepped_r;

`ifndef SYNTHESIS
  a_idle_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !is_fading_r) |-> (cur_level_r == target_level_r))
    else $error("idle and not fading but level differs from target");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    is_fading_r |-> (step_size_r != '0))
    else $error("fade active with zero step size");

  a_plan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    plan_rsp.done |-> (state_r == S_PLAN))
    else $error("planner finished outside of planning state");

  a_plan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLAN) |-> !out_valid_r)
    else $error("result register occupied while planning");
`endif

endmodule
